FILE: design/rpv_pkg.sv
package rpv_pkg;

	localparam logic [7:0] MAX_LENGTH_RESET = 8'd240;
	localparam logic [7:0] COUNT_MAX        = 8'd255;
	localparam logic [2:0] STEM_MAX         = 3'd5;
	localparam logic [2:0] STEM_KEEP        = 3'd4;
	localparam logic [2:0] STEM_THREE       = 3'd3;

	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_NONE  = 8'h00;

	// Reserved stems, first byte in the lowest bits
	localparam logic [23:0] STEM_CON = {8'h6E, 8'h6F, 8'h63};
	localparam logic [23:0] STEM_PRN = {8'h6E, 8'h72, 8'h70};
	localparam logic [23:0] STEM_AUX = {8'h78, 8'h75, 8'h61};
	localparam logic [23:0] STEM_NUL = {8'h6C, 8'h75, 8'h6E};
	localparam logic [23:0] STEM_COM = {8'h6D, 8'h6F, 8'h63};
	localparam logic [23:0] STEM_LPT = {8'h74, 8'h70, 8'h6C};

	typedef enum logic [1:0] {
		VERDICT_OK          = 2'd0,
		VERDICT_INVALID     = 2'd1,
		VERDICT_UNSAFE_CHAR = 2'd2,
		VERDICT_UNSAFE_COMP = 2'd3
	} verdict_t;

	typedef struct packed {
		logic       has_byte;
		logic [7:0] path_byte;
		logic       last;
	} item_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] path_length;
	} result_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_upper(input logic [7:0] c);
		return (c >= 8'h41) && (c <= 8'h5A);
	endfunction

	function automatic logic is_lower(input logic [7:0] c);
		return (c >= 8'h61) && (c <= 8'h7A);
	endfunction

	function automatic logic allowed_char(input logic [7:0] c);
		return is_lower(c) || is_upper(c) || is_digit(c) || (c == CH_SLASH) ||
			(c == CH_UNDER) || (c == CH_DASH) || (c == CH_DOT) ||
			(c == CH_BANG) || (c == CH_SPACE);
	endfunction

	function automatic logic [7:0] fold_char(input logic [7:0] c);
		return is_upper(c) ? (c | 8'h20) : c;
	endfunction

	// Unsafe finished component: trailing dot or space, or a reserved stem
	function automatic logic comp_bad(input logic [7:0] last_char,
		input logic [31:0] stem, input logic [2:0] len);
		logic [23:0] head;
		logic        bad;
		head = stem[23:0];
		bad  = (last_char == CH_DOT) || (last_char == CH_SPACE);
		if (len == STEM_THREE && (head == STEM_CON || head == STEM_PRN ||
			head == STEM_AUX || head == STEM_NUL))
			bad = 1'b1;
		if (len == STEM_KEEP && (head == STEM_COM || head == STEM_LPT) &&
			is_digit(stem[31:24]))
			bad = 1'b1;
		return (last_char != CH_NONE) && bad;
	endfunction

endpackage

FILE: design/rpv_in_stage.sv
module rpv_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rpv_pkg::item_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output rpv_pkg::item_t item_s1
);
	import rpv_pkg::*;

	assign in_ready = !valid_s1 || advance;

	// Hold the accepted item until the scan takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: design/rpv_scan.sv
module rpv_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cfg_we,
	input  logic [7:0]      cfg_wdata,
	input  logic            fire,
	input  rpv_pkg::item_t  item_s1,
	output rpv_pkg::result_t result
);
	import rpv_pkg::*;

	logic [7:0]  max_length_q;
	logic [7:0]  count_q, count_d;
	logic        first_slash_q, first_slash_d;
	logic        prev_slash_q, prev_slash_d;
	logic        dbl_slash_q, dbl_slash_d;
	logic        bad_char_q, bad_char_d;
	logic        bad_comp_q, bad_comp_d;
	logic [31:0] stem_q, stem_d;
	logic [2:0]  stem_len_q, stem_len_d;
	logic        in_stem_q, in_stem_d;
	logic [7:0]  comp_last_q, comp_last_d;
	logic        take, slash, final_bad_comp;
	logic [7:0]  c;

	assign c     = item_s1.path_byte;
	assign take  = item_s1.has_byte;
	assign slash = (c == CH_SLASH);

	// Apply one byte to the running path state
	always_comb begin
		count_d       = count_q;
		first_slash_d = first_slash_q;
		prev_slash_d  = prev_slash_q;
		dbl_slash_d   = dbl_slash_q;
		bad_char_d    = bad_char_q;
		bad_comp_d    = bad_comp_q;
		stem_d        = stem_q;
		stem_len_d    = stem_len_q;
		in_stem_d     = in_stem_q;
		comp_last_d   = comp_last_q;
		if (take) begin
			if (count_q == '0)
				first_slash_d = slash;
			if (count_q != COUNT_MAX)
				count_d = count_q + 8'd1;
			if (!allowed_char(c))
				bad_char_d = 1'b1;
			prev_slash_d = slash;
			if (slash) begin
				if (prev_slash_q)
					dbl_slash_d = 1'b1;
				if (comp_bad(comp_last_q, stem_q, stem_len_q))
					bad_comp_d = 1'b1;
				stem_d      = '0;
				stem_len_d  = '0;
				in_stem_d   = 1'b1;
				comp_last_d = CH_NONE;
			end else begin
				comp_last_d = c;
				if (c == CH_DOT) begin
					in_stem_d = 1'b0;
				end else if (in_stem_q) begin
					if (stem_len_q < STEM_KEEP)
						stem_d[{stem_len_q[1:0], 3'b000} +: 8] = fold_char(c);
					if (stem_len_q < STEM_MAX)
						stem_len_d = stem_len_q + 3'd1;
				end
			end
		end
	end

	// Close the open component and rank the checks
	assign final_bad_comp = bad_comp_d || comp_bad(comp_last_d, stem_d, stem_len_d);

	always_comb begin
		result.path_length = count_d;
		priority if (count_d == '0 || count_d > max_length_q || first_slash_d ||
			prev_slash_d)
			result.verdict = VERDICT_INVALID;
		else if (bad_char_d)
			result.verdict = VERDICT_UNSAFE_CHAR;
		else if (final_bad_comp)
			result.verdict = VERDICT_UNSAFE_COMP;
		else if (dbl_slash_d)
			result.verdict = VERDICT_INVALID;
		else
			result.verdict = VERDICT_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	// Advance the path state; clear it after the last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			first_slash_q <= 1'b0;
			prev_slash_q  <= 1'b0;
			dbl_slash_q   <= 1'b0;
			bad_char_q    <= 1'b0;
			bad_comp_q    <= 1'b0;
			stem_q        <= '0;
			stem_len_q    <= '0;
			in_stem_q     <= 1'b1;
			comp_last_q   <= CH_NONE;
		end else if (fire) begin
			if (item_s1.last) begin
				count_q       <= '0;
				first_slash_q <= 1'b0;
				prev_slash_q  <= 1'b0;
				dbl_slash_q   <= 1'b0;
				bad_char_q    <= 1'b0;
				bad_comp_q    <= 1'b0;
				stem_q        <= '0;
				stem_len_q    <= '0;
				in_stem_q     <= 1'b1;
				comp_last_q   <= CH_NONE;
			end else begin
				count_q       <= count_d;
				first_slash_q <= first_slash_d;
				prev_slash_q  <= prev_slash_d;
				dbl_slash_q   <= dbl_slash_d;
				bad_char_q    <= bad_char_d;
				bad_comp_q    <= bad_comp_d;
				stem_q        <= stem_d;
				stem_len_q    <= stem_len_d;
				in_stem_q     <= in_stem_d;
				comp_last_q   <= comp_last_d;
			end
		end
	end

endmodule

FILE: design/rpv_out_stage.sv
module rpv_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  rpv_pkg::result_t result,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output rpv_pkg::result_t result_s2
);
	import rpv_pkg::*;

	logic valid_s2;

	assign free      = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	// Hold the verdict until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (free) begin
			valid_s2 <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			result_s2 <= result;
		end
	end

endmodule

FILE: design/resource_path_validator.sv
// Channel   Dir  Handshake           Contents
// s_*       in   s_tvalid/s_tready   tdata path_byte, tuser has_byte, tlast last
// m_*       out  m_tvalid/m_tready   tdata verdict, path_length; tlast high
// cfg_*     in   cfg_we              cfg_wdata max_length
//
// One item per cycle sustained while the verdict output is not stalled. An item is
// registered in the input register, scanned against the running path flags, and on
// the last byte the verdict lands in the output register.
// Reset clears all path flags and sets max_length to 240.
// A stalled verdict holds the next path-ending item in the input register, and
// everything behind it waits; bytes ahead of that item keep flowing.
module resource_path_validator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] path_byte
	input  logic        s_tuser,   // [0] has_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [1:0] verdict, [9:2] path_length, [15:10] zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);
	import rpv_pkg::*;

	item_t   in_item, item_s1;
	result_t result, result_s2;
	logic    valid_s1, advance, fire, out_free;

	assign in_item = '{has_byte: s_tuser, path_byte: s_tdata, last: s_tlast};

	// Move the item on unless its verdict has nowhere to go
	assign advance = !item_s1.last || out_free;
	assign fire    = valid_s1 && advance;

	rpv_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rpv_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.fire      (fire),
		.item_s1   (item_s1),
		.result    (result)
	);

	rpv_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && item_s1.last),
		.result    (result),
		.free      (out_free),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.result_s2 (result_s2)
	);

	assign m_tdata = {6'd0, result_s2.path_length, result_s2.verdict};
	assign m_tlast = 1'b1;

endmodule
